@@ rtl/vrp_pkg.sv @@
// ----------------------------------------------------------------------------
// vrp_pkg
// Shared types, register indexes, projection codes and fixed-point helpers
// for the vertex rotate and project core.
// ----------------------------------------------------------------------------
package vrp_pkg;

  localparam int FRAC_BITS_DEF   = 14;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_TILT_Y  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TILT_X  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPIN_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ZOOM    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PROJ    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT   = 3'd7;

  localparam logic [1:0] MODE_NONE  = 2'd0;
  localparam logic [1:0] MODE_ISO30 = 2'd1;
  localparam logic [1:0] MODE_ISO26 = 2'd2;

  // isometric constants in Q30
  localparam longint ISO30_C_Q30 = 64'sd929887577;
  localparam longint ISO30_S_Q30 = 64'sd536871121;
  localparam longint ISO26_C_Q30 = 64'sd960342411;
  localparam longint ISO26_S_Q30 = 64'sd480274881;

  localparam logic [31:0] TRIG_RESET = 32'h4000_0000;

  typedef struct packed {
    logic signed [15:0] c;
    logic signed [15:0] s;
  } trig_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vertex_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // divide by 2^frac truncating toward zero, then saturate
  function automatic logic signed [31:0] fx_trunc(input logic signed [63:0] v,
                                                  input int frac);
    logic signed [63:0] bias;
    logic signed [63:0] t;
    bias = (64'sd1 <<< frac) - 64'sd1;
    t = v + (v[63] ? bias : 64'sd0);
    return sat32(t >>> frac);
  endfunction

  // Q30 constant rounded half up to frac fraction bits
  function automatic longint iso_frac(input longint k, input int frac);
    return (k + (64'sd1 <<< (29 - frac))) >>> (30 - frac);
  endfunction

endpackage

@@ rtl/vrp_front.sv @@
// ----------------------------------------------------------------------------
// vrp_front
// Input side: accepts vertices, scales x/y by zoom and z by height, then
// centers x/y. Two stages, feeding the queue.
// ----------------------------------------------------------------------------
module vrp_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [11:0]           grid_x,
  input  logic [11:0]           grid_y,
  input  logic signed [15:0]    height_z,
  input  logic [10:0]           zoom,
  input  logic signed [11:0]    hscale,
  input  logic [63:0]           center,
  input  logic                  push_ready,
  output logic                  push,
  output vrp_pkg::vertex_t      push_data
);

  logic                 f1v;
  logic                 f2v;
  logic                 f_en;
  logic [22:0]          mx;
  logic [22:0]          my;
  logic signed [27:0]   mz;
  logic signed [31:0]   x2;
  logic signed [31:0]   y2;
  logic signed [31:0]   z2;

  assign f_en     = !f2v || push_ready;
  assign in_ready = f_en;
  assign push     = f2v && push_ready;
  assign push_data = '{x: x2, y: y2, z: z2};

  always_ff @(posedge clk) begin
    if (rst) begin
      f1v <= 1'b0;
      f2v <= 1'b0;
    end else if (f_en) begin
      f1v <= in_valid;
      f2v <= f1v;
    end
  end

  always_ff @(posedge clk) begin
    if (f_en) begin
      mx <= 23'(grid_x) * 23'(zoom);
      my <= 23'(grid_y) * 23'(zoom);
      mz <= 28'(height_z) * 28'(hscale);
      x2 <= vrp_pkg::sat32($signed({41'd0, mx}) - 64'($signed(center[63:32])));
      y2 <= vrp_pkg::sat32($signed({41'd0, my}) - 64'($signed(center[31:0])));
      z2 <= 32'(mz);
    end
  end

endmodule

@@ rtl/vrp_fifo.sv @@
// ----------------------------------------------------------------------------
// vrp_fifo
// Short queue of scaled vertices between the front and the rotate pipeline.
// ----------------------------------------------------------------------------
module vrp_fifo #(
  parameter int DEPTH = vrp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  vrp_pkg::vertex_t  push_data,
  output logic              push_ready,
  input  logic              pop,
  output logic              pop_valid,
  output vrp_pkg::vertex_t  pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  vrp_pkg::vertex_t  mem [DEPTH];
  logic [AW-1:0]     wr_ptr;
  logic [AW-1:0]     rd_ptr;
  logic [CW-1:0]     count;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0) else $error("pop from empty queue");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH)) else $error("queue count overflow");

  a_count_inc: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1) else $error("count inc");

  a_count_dec: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> count == $past(count) - 1'b1) else $error("count dec");

endmodule

@@ rtl/vrp_rotate.sv @@
// ----------------------------------------------------------------------------
// vrp_rotate
// One plane rotation in three stages: products, sums, truncate/saturate.
// NEG_SIN=0: a' = a*c + b*s, b' = b*c - a*s
// NEG_SIN=1: a' = a*c - b*s, b' = b*c + a*s
// ----------------------------------------------------------------------------
module vrp_rotate #(
  parameter int FRAC_BITS = vrp_pkg::FRAC_BITS_DEF,
  parameter bit NEG_SIN   = 1'b0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic signed [31:0]  in_a,
  input  logic signed [31:0]  in_b,
  input  logic signed [31:0]  in_p,
  input  vrp_pkg::trig_t      trig,
  output logic                out_valid,
  output logic signed [31:0]  out_a,
  output logic signed [31:0]  out_b,
  output logic signed [31:0]  out_p
);

  localparam int PW = 48;
  localparam int SW = PW + 1;

  logic                 v1;
  logic                 v2;
  logic                 v3;
  logic signed [PW-1:0] pac;
  logic signed [PW-1:0] pbs;
  logic signed [PW-1:0] pas;
  logic signed [PW-1:0] pbc;
  logic signed [SW-1:0] sa;
  logic signed [SW-1:0] sb;
  logic signed [31:0]   p1;
  logic signed [31:0]   p2;
  logic signed [31:0]   p3;
  logic signed [31:0]   ra;
  logic signed [31:0]   rb;

  assign out_valid = v3;
  assign out_a     = ra;
  assign out_b     = rb;
  assign out_p     = p3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pac <= PW'(in_a) * PW'(trig.c);
      pbs <= PW'(in_b) * PW'(trig.s);
      pas <= PW'(in_a) * PW'(trig.s);
      pbc <= PW'(in_b) * PW'(trig.c);
      p1  <= in_p;
      if (NEG_SIN) begin
        sa <= SW'(pac) - SW'(pbs);
        sb <= SW'(pbc) + SW'(pas);
      end else begin
        sa <= SW'(pac) + SW'(pbs);
        sb <= SW'(pbc) - SW'(pas);
      end
      p2 <= p1;
      ra <= vrp_pkg::fx_trunc(64'(sa), FRAC_BITS);
      rb <= vrp_pkg::fx_trunc(64'(sb), FRAC_BITS);
      p3 <= p2;
    end
  end

endmodule

@@ rtl/vrp_project.sv @@
// ----------------------------------------------------------------------------
// vrp_project
// Optional isometric projection, screen offsets and the output register.
// ----------------------------------------------------------------------------
module vrp_project #(
  parameter int FRAC_BITS = vrp_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic signed [31:0]  in_x,
  input  logic signed [31:0]  in_y,
  input  logic signed [31:0]  in_z,
  input  logic [1:0]          mode,
  input  logic [63:0]         shift,
  output logic                out_valid,
  output logic signed [31:0]  screen_x,
  output logic signed [31:0]  screen_y,
  output logic signed [31:0]  depth_out
);

  localparam int IC_W = FRAC_BITS + 2;
  localparam int PW   = 33 + IC_W;

  localparam logic signed [IC_W-1:0] ISO30_C =
    IC_W'(vrp_pkg::iso_frac(vrp_pkg::ISO30_C_Q30, FRAC_BITS));
  localparam logic signed [IC_W-1:0] ISO30_S =
    IC_W'(vrp_pkg::iso_frac(vrp_pkg::ISO30_S_Q30, FRAC_BITS));
  localparam logic signed [IC_W-1:0] ISO26_C =
    IC_W'(vrp_pkg::iso_frac(vrp_pkg::ISO26_C_Q30, FRAC_BITS));
  localparam logic signed [IC_W-1:0] ISO26_S =
    IC_W'(vrp_pkg::iso_frac(vrp_pkg::ISO26_S_Q30, FRAC_BITS));

  logic                   iso;
  logic signed [IC_W-1:0] ic;
  logic signed [IC_W-1:0] is_k;

  logic [4:0]             v;
  logic signed [32:0]     d1;
  logic signed [32:0]     s1;
  logic signed [PW-1:0]   pd2;
  logic signed [PW-1:0]   ps2;
  logic signed [31:0]     fd3;
  logic signed [31:0]     fs3;
  logic signed [31:0]     x1, x2, x3, x4;
  logic signed [31:0]     y1, y2, y3, y4;
  logic signed [31:0]     z1, z2, z3, z4;
  logic signed [31:0]     sx;
  logic signed [31:0]     sy;
  logic signed [31:0]     sz;

  assign iso  = (mode == vrp_pkg::MODE_ISO30) || (mode == vrp_pkg::MODE_ISO26);
  assign ic   = (mode == vrp_pkg::MODE_ISO30) ? ISO30_C : ISO26_C;
  assign is_k = (mode == vrp_pkg::MODE_ISO30) ? ISO30_S : ISO26_S;

  assign out_valid = v[4];
  assign screen_x  = sx;
  assign screen_y  = sy;
  assign depth_out = sz;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1  <= 33'(in_x) - 33'(in_y);
      s1  <= 33'(in_x) + 33'(in_y);
      x1  <= in_x;
      y1  <= in_y;
      z1  <= in_z;

      pd2 <= PW'(d1) * PW'(ic);
      ps2 <= PW'(s1) * PW'(is_k);
      x2  <= x1;
      y2  <= y1;
      z2  <= z1;

      fd3 <= vrp_pkg::fx_trunc(64'(pd2), FRAC_BITS);
      fs3 <= vrp_pkg::fx_trunc(64'(ps2), FRAC_BITS);
      x3  <= x2;
      y3  <= y2;
      z3  <= z2;

      if (iso) begin
        x4 <= fd3;
        y4 <= vrp_pkg::sat32(64'(fs3) - 64'(z3));
      end else begin
        x4 <= x3;
        y4 <= y3;
      end
      z4 <= z3;

      sx <= vrp_pkg::sat32(64'(x4) + 64'($signed(shift[63:32])));
      sy <= vrp_pkg::sat32(64'(y4) + 64'($signed(shift[31:0])));
      sz <= z4;
    end
  end

endmodule

@@ rtl/vertex_rotate_project_core.sv @@
// ----------------------------------------------------------------------------
// vertex_rotate_project_core
// Map vertex scale, three-axis rotation, isometric projection and offset.
// ----------------------------------------------------------------------------
// Takes one vertex per clock and returns one result per clock, sustained, while
// the output is not stalled. An item passes 17 register stages: 2 front
// stages, the queue, 3 stages per rotation and 5 projection/offset stages,
// the last being the output register. The front runs ahead into a queue of
// QUEUE_DEPTH items while the output is stalled. The user must write
// configuration only while no item is in flight; the block does not check it.
module vertex_rotate_project_core #(
  parameter int FRAC_BITS   = vrp_pkg::FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH = vrp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [vrp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [vrp_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [11:0]                       grid_x,
  input  logic [11:0]                       grid_y,
  input  logic signed [15:0]                height_z,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [31:0]                screen_x,
  output logic signed [31:0]                screen_y,
  output logic signed [31:0]                depth_out
);

  vrp_pkg::trig_t      tilt_y_trig;
  vrp_pkg::trig_t      tilt_x_trig;
  vrp_pkg::trig_t      spin_z_trig;
  logic [10:0]         zoom_factor;
  logic signed [11:0]  height_scale;
  logic [1:0]          projection_mode;
  logic [63:0]         pre_center;
  logic [63:0]         post_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      tilt_y_trig     <= vrp_pkg::TRIG_RESET;
      tilt_x_trig     <= vrp_pkg::TRIG_RESET;
      spin_z_trig     <= vrp_pkg::TRIG_RESET;
      zoom_factor     <= 11'd1;
      height_scale    <= 12'sd1;
      projection_mode <= vrp_pkg::MODE_NONE;
      pre_center      <= '0;
      post_shift      <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        vrp_pkg::REG_TILT_Y: tilt_y_trig     <= cfg_data[31:0];
        vrp_pkg::REG_TILT_X: tilt_x_trig     <= cfg_data[31:0];
        vrp_pkg::REG_SPIN_Z: spin_z_trig     <= cfg_data[31:0];
        vrp_pkg::REG_ZOOM:   zoom_factor     <= cfg_data[10:0];
        vrp_pkg::REG_HEIGHT: height_scale    <= cfg_data[11:0];
        vrp_pkg::REG_PROJ:   projection_mode <= cfg_data[1:0];
        vrp_pkg::REG_CENTER: pre_center      <= cfg_data;
        vrp_pkg::REG_SHIFT:  post_shift      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  logic              en;
  logic              push;
  logic              push_ready;
  vrp_pkg::vertex_t  push_data;
  logic              pop;
  logic              pop_valid;
  vrp_pkg::vertex_t  pop_data;

  assign en  = !out_valid || out_ready;
  assign pop = pop_valid && en;

  vrp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .grid_x     (grid_x),
    .grid_y     (grid_y),
    .height_z   (height_z),
    .zoom       (zoom_factor),
    .hscale     (height_scale),
    .center     (pre_center),
    .push_ready (push_ready),
    .push       (push),
    .push_data  (push_data)
  );

  vrp_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data)
  );

  logic               b_valid, a_valid, g_valid;
  logic signed [31:0] b_x, b_y, b_z;
  logic signed [31:0] a_x, a_y, a_z;
  logic signed [31:0] g_x, g_y, g_z;

  // beta: (x, z), y passes
  vrp_rotate #(.FRAC_BITS(FRAC_BITS), .NEG_SIN(1'b0)) u_rot_beta (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (pop_valid),
    .in_a      (pop_data.x),
    .in_b      (pop_data.z),
    .in_p      (pop_data.y),
    .trig      (tilt_y_trig),
    .out_valid (b_valid),
    .out_a     (b_x),
    .out_b     (b_z),
    .out_p     (b_y)
  );

  // alpha: (y, z), x passes
  vrp_rotate #(.FRAC_BITS(FRAC_BITS), .NEG_SIN(1'b0)) u_rot_alpha (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (b_valid),
    .in_a      (b_y),
    .in_b      (b_z),
    .in_p      (b_x),
    .trig      (tilt_x_trig),
    .out_valid (a_valid),
    .out_a     (a_y),
    .out_b     (a_z),
    .out_p     (a_x)
  );

  // gamma: (x, y), z passes
  vrp_rotate #(.FRAC_BITS(FRAC_BITS), .NEG_SIN(1'b1)) u_rot_gamma (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (a_valid),
    .in_a      (a_x),
    .in_b      (a_y),
    .in_p      (a_z),
    .trig      (spin_z_trig),
    .out_valid (g_valid),
    .out_a     (g_x),
    .out_b     (g_y),
    .out_p     (g_z)
  );

  vrp_project #(.FRAC_BITS(FRAC_BITS)) u_project (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (g_valid),
    .in_x      (g_x),
    .in_y      (g_y),
    .in_z      (g_z),
    .mode      (projection_mode),
    .shift     (post_shift),
    .out_valid (out_valid),
    .screen_x  (screen_x),
    .screen_y  (screen_y),
    .depth_out (depth_out)
  );

endmodule
